@@ rtl/csvt_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csvt_pkg
// Shared types, byte codes and register map of the CSV field tokenizer.
// ---------------------------------------------------------------------------
package csvt_pkg;

    localparam logic [7:0] QUOTE_CHAR = 8'h22;
    localparam logic [7:0] CR_CHAR    = 8'h0D;
    localparam logic [7:0] SEP_RESET  = 8'd44;

    // APB register map: one register, index taken from paddr[2]
    localparam int   ADDR_W  = 3;
    localparam logic REG_SEP = 1'b0;

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [4:0] {
        MODE_START = 5'b00001,
        MODE_UNQ   = 5'b00010,
        MODE_QUO   = 5'b00100,
        MODE_QQ    = 5'b01000,
        MODE_AFTER = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       field_done;
        logic       line_done;
        logic       open_quote_error;
        logic       run_last;
    } t_result;

    // Everything one byte produces: up to two results plus the next state
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
        t_mode      mode;
        logic       cr_pend;
    } t_step;

    function automatic t_result mk_result(input logic valid, input logic [7:0] ch,
                                          input logic fd, input logic ld,
                                          input logic err);
        t_result r;
        r.out_char         = valid ? ch : 8'h00;
        r.char_valid       = valid;
        r.field_done       = fd;
        r.line_done        = ld;
        r.open_quote_error = err;
        r.run_last         = 1'b0;
        return r;
    endfunction

endpackage

@@ rtl/csvt_parse.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csvt_parse
// Decode one byte against the parse state: results and next state.
// ---------------------------------------------------------------------------
module csvt_parse import csvt_pkg::*; (
    input  logic [7:0] i_char,
    input  logic       i_eol,
    input  logic [7:0] i_sep,
    input  t_mode      i_mode,
    input  logic       i_cr_pend,
    output t_step      o_step
);

    logic    is_q, is_cr, is_sep;
    logic    lead, done;
    t_mode   p_mode_in, p_mode;
    logic    p_pend;
    logic [1:0] p_cnt;
    t_result p_r0, p_r1;

    assign is_q   = (i_char == QUOTE_CHAR);
    assign is_cr  = (i_char == CR_CHAR);
    assign is_sep = (i_char == i_sep);

    // Byte outside quotes: field start, unquoted content, after a closing quote
    always_comb begin
        unique case (i_mode)
            MODE_START:          p_mode_in = MODE_START;
            MODE_QQ, MODE_AFTER: p_mode_in = MODE_AFTER;
            default:             p_mode_in = MODE_UNQ;
        endcase
        p_cnt  = 2'd0;
        p_r0   = '0;
        p_r1   = '0;
        p_mode = p_mode_in;
        p_pend = i_cr_pend;
        lead   = 1'b0;
        done   = 1'b0;
        // held carriage return: drop before a separator, release otherwise
        if (i_cr_pend) begin
            if (is_sep) begin
                p_pend = 1'b0;
            end else if (is_cr && i_eol) begin
                p_r0   = mk_result(1'b1, CR_CHAR, 1'b1, 1'b1, 1'b0);
                p_cnt  = 2'd1;
                p_pend = 1'b0;
                done   = 1'b1;
            end else if (is_cr) begin
                p_r0  = mk_result(1'b1, CR_CHAR, 1'b0, 1'b0, 1'b0);
                p_cnt = 2'd1;
                done  = 1'b1;
            end else begin
                p_r0   = mk_result(1'b1, CR_CHAR, 1'b0, 1'b0, 1'b0);
                p_cnt  = 2'd1;
                p_pend = 1'b0;
                lead   = 1'b1;
            end
        end
        if (!done) begin
            if (is_sep) begin
                p_r0  = mk_result(1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
                p_cnt = 2'd1;
                if (i_eol) begin
                    p_r1  = mk_result(1'b0, 8'h00, 1'b1, 1'b1, 1'b0);
                    p_cnt = 2'd2;
                end
                p_mode = MODE_START;
            end else if (is_cr) begin
                if (i_eol) begin
                    p_r0  = mk_result(1'b0, 8'h00, 1'b1, 1'b1, 1'b0);
                    p_cnt = 2'd1;
                end else begin
                    p_pend = 1'b1;
                    if (p_mode_in == MODE_START) p_mode = MODE_UNQ;
                end
            end else begin
                if (lead) begin
                    p_r1  = mk_result(1'b1, i_char, i_eol, i_eol, 1'b0);
                    p_cnt = 2'd2;
                end else begin
                    p_r0  = mk_result(1'b1, i_char, i_eol, i_eol, 1'b0);
                    p_cnt = 2'd1;
                end
                if (p_mode_in == MODE_START) p_mode = MODE_UNQ;
            end
        end
    end

    always_comb begin
        o_step.count   = 2'd0;
        o_step.res0    = '0;
        o_step.res1    = '0;
        o_step.mode    = i_mode;
        o_step.cr_pend = i_cr_pend;
        unique case (i_mode)
            MODE_START: begin
                if (is_q) begin
                    if (i_eol) begin
                        o_step.res0  = mk_result(1'b0, 8'h00, 1'b1, 1'b1, 1'b1);
                        o_step.count = 2'd1;
                    end else begin
                        o_step.mode = MODE_QUO;
                    end
                end else begin
                    o_step.count   = p_cnt;
                    o_step.res0    = p_r0;
                    o_step.res1    = p_r1;
                    o_step.mode    = p_mode;
                    o_step.cr_pend = p_pend;
                end
            end
            MODE_QUO: begin
                if (is_q) begin
                    if (i_eol) begin
                        o_step.res0  = mk_result(1'b0, 8'h00, 1'b1, 1'b1, 1'b0);
                        o_step.count = 2'd1;
                    end else begin
                        o_step.mode = MODE_QQ;
                    end
                end else if (i_eol) begin
                    o_step.res0  = mk_result(!is_cr, i_char, 1'b1, 1'b1, 1'b1);
                    o_step.count = 2'd1;
                end else begin
                    o_step.res0  = mk_result(1'b1, i_char, 1'b0, 1'b0, 1'b0);
                    o_step.count = 2'd1;
                end
            end
            MODE_QQ: begin
                if (is_q) begin
                    // doubled quote: one literal quote
                    o_step.res0  = mk_result(1'b1, QUOTE_CHAR, i_eol, i_eol, i_eol);
                    o_step.count = 2'd1;
                    o_step.mode  = MODE_QUO;
                end else begin
                    o_step.count   = p_cnt;
                    o_step.res0    = p_r0;
                    o_step.res1    = p_r1;
                    o_step.mode    = p_mode;
                    o_step.cr_pend = p_pend;
                end
            end
            default: begin
                o_step.count   = p_cnt;
                o_step.res0    = p_r0;
                o_step.res1    = p_r1;
                o_step.mode    = p_mode;
                o_step.cr_pend = p_pend;
            end
        endcase
        if (i_eol) begin
            o_step.mode    = MODE_START;
            o_step.cr_pend = 1'b0;
        end
        if (o_step.count == 2'd2) begin
            o_step.res1.run_last = 1'b1;
        end else if (o_step.count == 2'd1) begin
            o_step.res0.run_last = 1'b1;
        end
    end

endmodule

@@ rtl/csvt_outq.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csvt_outq
// Small result queue: takes zero, one or two results, hands out one.
// ---------------------------------------------------------------------------
module csvt_outq import csvt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_result    i_res0,
    input  t_result    i_res1,
    output logic       o_room2,
    output logic       o_valid,
    output t_result    o_res,
    input  logic       i_ready
);

    t_result             r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr, n_wptr;
    logic [QPTR_W-1:0]   r_rptr, n_rptr;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;
    logic [QPTR_W-1:0]   wptr1;
    logic                pop;

    assign o_valid = (r_cnt != '0);
    assign o_room2 = (r_cnt <= QCNT_W'(QDEPTH - 2));
    assign o_res   = r_mem[r_rptr];
    assign pop     = o_valid && i_ready;
    assign wptr1   = r_wptr + QPTR_W'(1);

    always_comb begin
        n_cnt  = r_cnt + QCNT_W'(i_push_cnt) - QCNT_W'(pop);
        n_wptr = r_wptr + QPTR_W'(i_push_cnt);
        n_rptr = r_rptr + QPTR_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wptr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wptr1] <= i_res1;
        end
    end

endmodule

@@ rtl/csv_field_tokenizer.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csv_field_tokenizer
// Streaming CSV field parser: raw line bytes in, unescaped field bytes and
// field/line end marks out.
// ---------------------------------------------------------------------------
// Usage
//   Input channel (i_valid/o_ready): one raw byte per transfer, with
//   i_end_of_line high on the last byte of a line.
//   Output channel (o_valid/i_ready): one result per transfer; a byte yields
//   zero, one or two results, and o_run_last marks the last one of a byte.
//   Quoted fields are unescaped, a held carriage return is dropped before a
//   field end, and a line that ends inside open quotes flags the last field
//   with o_open_quote_error.
//   Separator byte: APB register 0 (byte address 0), reset to a comma.
// Timing
//   A byte is held in an input register, decoded combinationally and written
//   to a four-entry result queue, which drives the output. One byte is taken
//   per cycle as long as the queue has room for two results; the output side
//   drains one result per cycle while i_ready is high, so bytes that yield
//   two results take two output transfers.
// Reset and stalls
//   Reset empties the queue and the input register, returns to field start
//   and restores the comma separator. When the receiver stalls, results
//   collect in the queue; once it holds more than two results the input
//   register holds its byte and o_ready drops after the register fills.
// ---------------------------------------------------------------------------
module csv_field_tokenizer import csvt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte input
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_in_char,
    input  logic              i_end_of_line,
    // result output
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_out_char,
    output logic              o_char_valid,
    output logic              o_field_done,
    output logic              o_line_done,
    output logic              o_open_quote_error,
    output logic              o_run_last,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // configuration register
    logic [7:0] r_sep;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_eol;

    // parse state
    t_mode      r_mode;
    logic       r_cr_pend;

    t_step      step;
    logic       q_room2;
    logic       advance;
    logic [1:0] push_cnt;
    t_result    q_res;
    logic       in_xfer;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SEP) ? {24'h000000, r_sep} : 32'h0000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= SEP_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SEP)) begin
            r_sep <= pwdata[7:0];
        end
    end

    // Advance the held byte whenever the queue can take its worst case of two
    assign advance  = r_in_valid && q_room2;
    assign o_ready  = !r_in_valid || advance;
    assign in_xfer  = i_valid && o_ready;
    assign push_cnt = advance ? step.count : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_char <= i_in_char;
            r_in_eol  <= i_end_of_line;
        end
    end

    csvt_parse u_parse (
        .i_char    (r_in_char),
        .i_eol     (r_in_eol),
        .i_sep     (r_sep),
        .i_mode    (r_mode),
        .i_cr_pend (r_cr_pend),
        .o_step    (step)
    );

    // Commit the next parse state only when the byte moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_START;
            r_cr_pend <= 1'b0;
        end else if (advance) begin
            r_mode    <= step.mode;
            r_cr_pend <= step.cr_pend;
        end
    end

    csvt_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (step.res0),
        .i_res1     (step.res1),
        .o_room2    (q_room2),
        .o_valid    (o_valid),
        .o_res      (q_res),
        .i_ready    (i_ready)
    );

    assign o_out_char         = q_res.out_char;
    assign o_char_valid       = q_res.char_valid;
    assign o_field_done       = q_res.field_done;
    assign o_line_done        = q_res.line_done;
    assign o_open_quote_error = q_res.open_quote_error;
    assign o_run_last         = q_res.run_last;

endmodule

@@ rtl/csvt_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csvt_props
// Port-level checks on the tokenizer's result stream.
// ---------------------------------------------------------------------------
module csvt_props (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_char,
    input logic       o_char_valid,
    input logic       o_field_done,
    input logic       o_line_done,
    input logic       o_open_quote_error,
    input logic       o_run_last
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_char) && $stable(o_char_valid)
            && $stable(o_field_done) && $stable(o_line_done) && $stable(o_run_last))
        else $error("stalled result changed");

    a_line_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_done |-> o_field_done)
        else $error("line end without field end");

    a_err_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_open_quote_error |-> o_line_done)
        else $error("quote error off a line end");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_char_valid |-> o_out_char == 8'h00)
        else $error("non-content result carries a byte");

    a_line_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_done |-> o_run_last)
        else $error("line end not last result of its byte");

endmodule

bind csv_field_tokenizer csvt_props u_csvt_props (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_out_char         (o_out_char),
    .o_char_valid       (o_char_valid),
    .o_field_done       (o_field_done),
    .o_line_done        (o_line_done),
    .o_open_quote_error (o_open_quote_error),
    .o_run_last         (o_run_last)
);
